>>> sv/fpha_pkg.sv
// ----------------------------------------------------------------------------
// Hole allocator package
// Shared types and codes for the fit policy hole allocator.
// ----------------------------------------------------------------------------
package fpha_pkg;

   localparam int FIELD_BITS = 16;
   localparam int EXT_BITS   = 32;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_ALLOC  = 2'd2,
      OP_NOP    = 2'd3
   } fpha_op_type;

   typedef enum logic [1:0] {
      MODE_FIRST = 2'd0,
      MODE_BEST  = 2'd1,
      MODE_WORST = 2'd2
   } fpha_mode_type;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NO_FIT = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_UPDATE,
      S_SHIFT,
      S_DONE
   } fpha_state_type;

   typedef struct packed {
      logic clear;
      logic eval;
   } fpha_fit_ctrl_type;

endpackage

>>> sv/fpha_if.sv
// ----------------------------------------------------------------------------
// Hole allocator channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface fpha_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          operation;
   logic [fpha_pkg::FIELD_BITS-1:0]     hole_base;
   logic [fpha_pkg::FIELD_BITS-1:0]     request_size;

   modport source (output valid, output operation, output hole_base,
                   output request_size, input ready);
   modport sink   (input valid, input operation, input hole_base,
                   input request_size, output ready);
endinterface

interface fpha_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                accepted;
   logic [fpha_pkg::FIELD_BITS-1:0]     alloc_start;
   logic [1:0]                          status;

   modport source (output valid, output accepted, output alloc_start,
                   output status, input ready);
   modport sink   (input valid, input accepted, input alloc_start,
                   input status, output ready);
endinterface

>>> sv/fpha_hole_mem.sv
// ----------------------------------------------------------------------------
// Hole table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fpha_hole_mem #(
   parameter int ENTRIES   = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  logic [WORD_BITS-1:0]       wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(ENTRIES)-1:0] rd_addr,
   output logic [WORD_BITS-1:0]       rd_data_ff
);

   logic [WORD_BITS-1:0] mem_ff [ENTRIES];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

endmodule

>>> sv/fpha_fit_unit.sv
// ----------------------------------------------------------------------------
// Fit compare unit
// Compares one hole per beat against the request and keeps the current pick.
// ----------------------------------------------------------------------------
module fpha_fit_unit #(
   parameter int ENTRIES   = 16,
   parameter int ADDR_BITS = 16
) (
   input  logic                       clock,
   input  fpha_pkg::fpha_fit_ctrl_type ctrl,
   input  logic [1:0]                 mode,
   input  logic [ADDR_BITS-1:0]       size,
   input  logic [ADDR_BITS-1:0]       hole_start,
   input  logic [ADDR_BITS-1:0]       hole_len,
   input  logic [$clog2(ENTRIES)-1:0] hole_idx,
   output logic                       found_ff,
   output logic [$clog2(ENTRIES)-1:0] pick_idx_ff,
   output logic [ADDR_BITS-1:0]       pick_start_ff,
   output logic [ADDR_BITS-1:0]       pick_len_ff
);
   import fpha_pkg::*;

   logic qualifies;
   logic better;

   always_comb begin
      qualifies = (hole_len >= size);
      case (mode)
         MODE_BEST:  better = !found_ff || (hole_len < pick_len_ff);
         MODE_WORST: better = !found_ff || (hole_len > pick_len_ff);
         default:    better = !found_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.clear) begin
         found_ff <= 1'b0;
      end else if (ctrl.eval && qualifies && better) begin
         found_ff      <= 1'b1;
         pick_idx_ff   <= hole_idx;
         pick_start_ff <= hole_start;
         pick_len_ff   <= hole_len;
      end
   end

endmodule

>>> sv/fit_policy_hole_allocator.sv
// Sequence: clear, append and unknown operations, and allocate on an empty table, go straight to
// the response; allocate on a non-empty table scans every hole, then updates the pick, and
// moves later holes up one place when the chosen hole empties.
// Throughput: one request at a time; the single compare unit scans one hole per cycle.
// Reset: synchronous; empties the table, selects first fit and drops any response.
// ----------------------------------------------------------------------------
// Fit policy hole allocator
// Hole table with first, best and worst fit allocation under a small sequencer.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator #(
   parameter int TABLE_ENTRIES = 16,
   parameter int ADDRESS_BITS  = 16
) (
   input  logic       clock,
   input  logic       reset,
   fpha_req_if.sink   req,
   fpha_rsp_if.source rsp,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);
   import fpha_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int AB    = ADDRESS_BITS;

   fpha_state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff;
   logic [1:0]       mode_ff;
   logic [AB-1:0]    size_ff;
   logic [CNT_W-1:0] idx_ff;
   logic             pend_ff;
   logic [IDX_W-1:0] pend_idx_ff;
   logic             res_acc_ff;
   logic [AB-1:0]    res_start_ff;
   logic [1:0]       res_status_ff;
   logic             rsp_valid_ff;
   logic             rsp_acc_ff;
   logic [FIELD_BITS-1:0] rsp_start_ff;
   logic [1:0]       rsp_status_ff;

   logic             accept;
   logic [EXT_BITS-1:0] base_ext, size_ext, start_ext;
   logic [AB-1:0]    req_base, req_size;
   logic             slot_free;
   logic [AB-1:0]    new_len;
   logic             last_pick;

   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_wa, mem_ra;
   logic [2*AB-1:0]  mem_wd, mem_rd;
   fpha_fit_ctrl_type fit_ctrl;

   logic             found;
   logic [IDX_W-1:0] pick_idx;
   logic [AB-1:0]    pick_start, pick_len;

   fpha_hole_mem #(
      .ENTRIES   (TABLE_ENTRIES),
      .WORD_BITS (2 * AB)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_wa),
      .wr_data    (mem_wd),
      .rd_en      (mem_re),
      .rd_addr    (mem_ra),
      .rd_data_ff (mem_rd)
   );

   fpha_fit_unit #(
      .ENTRIES   (TABLE_ENTRIES),
      .ADDR_BITS (AB)
   ) u_fit (
      .clock         (clock),
      .ctrl          (fit_ctrl),
      .mode          (mode_ff),
      .size          (size_ff),
      .hole_start    (mem_rd[2*AB-1:AB]),
      .hole_len      (mem_rd[AB-1:0]),
      .hole_idx      (pend_idx_ff),
      .found_ff      (found),
      .pick_idx_ff   (pick_idx),
      .pick_start_ff (pick_start),
      .pick_len_ff   (pick_len)
   );

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;

   assign base_ext  = {{(EXT_BITS - FIELD_BITS){1'b0}}, req.hole_base};
   assign size_ext  = {{(EXT_BITS - FIELD_BITS){1'b0}}, req.request_size};
   assign req_base  = base_ext[AB-1:0];
   assign req_size  = size_ext[AB-1:0];
   assign start_ext = EXT_BITS'(res_start_ff);

   assign new_len   = pick_len - size_ff;
   assign last_pick = (CNT_W'(pick_idx) == count_ff - CNT_W'(1));

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.accepted    = rsp_acc_ff;
   assign rsp.alloc_start = rsp_start_ff;
   assign rsp.status      = rsp_status_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (fpha_op_type'(req.operation) == OP_ALLOC && count_ff != '0) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (idx_ff == count_ff) begin
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            if (!found || new_len != '0 || last_pick) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            // The count has already dropped by one, so the old count is one more.
            if (idx_ff == count_ff + CNT_W'(1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory and compare unit control
   always_comb begin
      mem_we         = 1'b0;
      mem_wa         = '0;
      mem_wd         = '0;
      mem_re         = 1'b0;
      mem_ra         = idx_ff[IDX_W-1:0];
      fit_ctrl.clear = 1'b0;
      fit_ctrl.eval  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            fit_ctrl.clear = 1'b1;
            if (accept && fpha_op_type'(req.operation) == OP_APPEND && req_size != '0
                && count_ff != CNT_W'(TABLE_ENTRIES)) begin
               mem_we = 1'b1;
               mem_wa = count_ff[IDX_W-1:0];
               mem_wd = {req_base, req_size};
            end
         end
         S_SCAN: begin
            mem_re        = (idx_ff < count_ff);
            fit_ctrl.eval = pend_ff;
         end
         S_UPDATE: begin
            if (found && new_len != '0) begin
               mem_we = 1'b1;
               mem_wa = pick_idx;
               mem_wd = {pick_start + size_ff, new_len};
            end
         end
         S_SHIFT: begin
            mem_re = (idx_ff < count_ff + CNT_W'(1));
            if (pend_ff) begin
               mem_we = 1'b1;
               mem_wa = pend_idx_ff - IDX_W'(1);
               mem_wd = mem_rd;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         mode_ff      <= MODE_FIRST;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  size_ff      <= req_size;
                  idx_ff       <= '0;
                  pend_ff      <= 1'b0;
                  res_start_ff <= '0;
                  case (fpha_op_type'(req.operation))
                     OP_CLEAR: begin
                        count_ff      <= '0;
                        res_acc_ff    <= 1'b1;
                        res_status_ff <= STAT_OK;
                     end
                     OP_APPEND: begin
                        if (req_size == '0) begin
                           res_acc_ff    <= 1'b1;
                           res_status_ff <= STAT_OK;
                        end else if (count_ff == CNT_W'(TABLE_ENTRIES)) begin
                           res_acc_ff    <= 1'b0;
                           res_status_ff <= STAT_FULL;
                        end else begin
                           count_ff      <= count_ff + CNT_W'(1);
                           res_acc_ff    <= 1'b1;
                           res_status_ff <= STAT_OK;
                        end
                     end
                     OP_ALLOC: begin
                        res_acc_ff    <= 1'b0;
                        res_status_ff <= STAT_NO_FIT;
                     end
                     default: begin
                        res_acc_ff    <= 1'b0;
                        res_status_ff <= STAT_OK;
                     end
                  endcase
               end
            end
            S_SCAN, S_SHIFT: begin
               pend_ff     <= mem_re;
               pend_idx_ff <= idx_ff[IDX_W-1:0];
               if (mem_re) begin
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            S_UPDATE: begin
               pend_ff <= 1'b0;
               if (found) begin
                  res_acc_ff    <= 1'b1;
                  res_status_ff <= STAT_OK;
                  res_start_ff  <= pick_start;
                  if (new_len == '0) begin
                     // The emptied hole leaves; later holes are copied up one place.
                     count_ff <= count_ff - CNT_W'(1);
                     idx_ff   <= CNT_W'(pick_idx) + CNT_W'(1);
                  end
               end
            end
            default: begin
            end
         endcase

         if (state_ff == S_DONE && slot_free) begin
            rsp_valid_ff  <= 1'b1;
            rsp_acc_ff    <= res_acc_ff;
            rsp_start_ff  <= start_ext[FIELD_BITS-1:0];
            rsp_status_ff <= res_status_ff;
         end else if (rsp_valid_ff && rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
